@@ rtl/assert_macros.svh @@
// assertion helper macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold on every clock edge when not in reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// implication checked on every clock edge when not in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`endif

@@ rtl/slpi_pkg.sv @@
// shared constants and types for the server list parse and insert block
// no dependencies
package slpi_pkg;
   localparam int MainDepth = 2048;
   localparam int SecDepth = 128;
   localparam int RecPerPkt = 256;
   localparam int MainAw = $clog2(MainDepth);
   localparam int SecAw = $clog2(SecDepth);
   localparam int FillW = MainAw + 1;
   localparam int SecFillW = SecAw + 1;
   localparam int PktW = $clog2(RecPerPkt + 1);

   localparam logic [7:0] BSLASH = 8'h5C;
   localparam logic [7:0] CH_E = 8'h45;
   localparam logic [7:0] CH_O = 8'h4F;
   localparam logic [7:0] CH_T = 8'h54;

   localparam logic [2:0] EV_MAIN = 3'd0;
   localparam logic [2:0] EV_OVER = 3'd1;
   localparam logic [2:0] EV_DUP = 3'd2;
   localparam logic [2:0] EV_FULL = 3'd3;
   localparam logic [2:0] EV_END = 3'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic [10:0] slot;
      logic [47:0] rec;
      logic [11:0] main_count;
      logic [11:0] over_count;
      logic done;
   } rsp_type;

   // request from parser to the list unit, mode is always the current one
   typedef struct packed {
      logic start;
      logic mode;
      logic [47:0] rec;
   } ins_req_type;
endpackage

@@ rtl/slpi_lists.sv @@
// list storage and the duplicate scan over the main list
// depends on slpi_pkg and assert_macros.svh
`include "assert_macros.svh"
module slpi_lists (
   input logic clock,
   input logic reset,
   input slpi_pkg::ins_req_type req,
   input logic pkt_end,
   output logic busy,
   output logic fin,
   output logic [2:0] kind,
   output logic [10:0] slot,
   output logic [11:0] main_count,
   output logic [11:0] over_count
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_CMP = 2'd2;

   logic [47:0] main_mem [slpi_pkg::MainDepth];
   logic [47:0] over_mem [slpi_pkg::MainDepth];
   logic [47:0] sec_mem [slpi_pkg::SecDepth];
   logic [47:0] rd_ff;

   logic [1:0] state_ff, state_in;
   logic [slpi_pkg::FillW-1:0] main_fill_ff, main_fill_in;
   logic [slpi_pkg::FillW-1:0] over_fill_ff, over_fill_in;
   logic [slpi_pkg::SecFillW-1:0] sec_fill_ff, sec_fill_in;
   logic [slpi_pkg::FillW-1:0] start_fill_ff, start_fill_in;
   logic [slpi_pkg::FillW-1:0] idx_ff, idx_in;
   logic [47:0] rec_ff, rec_in;
   logic mode_ff, mode_in;
   logic fin_in, fin_ff;
   logic [2:0] kind_in, kind_ff;
   logic [10:0] slot_in, slot_ff;
   logic wr_main, wr_over, wr_sec;
   logic [slpi_pkg::MainAw-1:0] rd_addr;

   assign rd_addr = idx_ff[slpi_pkg::MainAw-1:0];

   always_ff @(posedge clock) begin
      rd_ff <= main_mem[rd_addr];
      if (wr_main) main_mem[main_fill_ff[slpi_pkg::MainAw-1:0]] <= rec_ff;
      if (wr_over) over_mem[over_fill_ff[slpi_pkg::MainAw-1:0]] <= rec_ff;
      if (wr_sec) sec_mem[sec_fill_ff[slpi_pkg::SecAw-1:0]] <= rec_ff;
   end

   // duplicate scan over the main list and the store decision; mode 0 stores to the secondary list with no scan
   always_comb begin
      state_in = state_ff;
      main_fill_in = main_fill_ff;
      over_fill_in = over_fill_ff;
      sec_fill_in = sec_fill_ff;
      start_fill_in = start_fill_ff;
      idx_in = idx_ff;
      rec_in = rec_ff;
      mode_in = mode_ff;
      fin_in = 1'b0;
      kind_in = kind_ff;
      slot_in = slot_ff;
      wr_main = 1'b0;
      wr_over = 1'b0;
      wr_sec = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               rec_in = req.rec;
               mode_in = req.mode;
               idx_in = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (!mode_ff) begin
               slot_in = '0;
               kind_in = slpi_pkg::EV_FULL;
               if (sec_fill_ff < slpi_pkg::SecFillW'(slpi_pkg::SecDepth)) begin
                  wr_sec = 1'b1;
                  slot_in = 11'(sec_fill_ff);
                  kind_in = slpi_pkg::EV_MAIN;
                  sec_fill_in = sec_fill_ff + 1'b1;
               end
               fin_in = 1'b1;
               state_in = S_IDLE;
            end else if (idx_ff < start_fill_ff) begin
               state_in = S_CMP;
            end else begin
               slot_in = '0;
               kind_in = slpi_pkg::EV_FULL;
               if (main_fill_ff < slpi_pkg::FillW'(slpi_pkg::MainDepth)) begin
                  wr_main = 1'b1;
                  slot_in = 11'(main_fill_ff);
                  kind_in = slpi_pkg::EV_MAIN;
                  main_fill_in = main_fill_ff + 1'b1;
               end else if (over_fill_ff < slpi_pkg::FillW'(slpi_pkg::MainDepth)) begin
                  wr_over = 1'b1;
                  slot_in = 11'(over_fill_ff);
                  kind_in = slpi_pkg::EV_OVER;
                  over_fill_in = over_fill_ff + 1'b1;
               end
               fin_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CMP: begin
            if (rd_ff == rec_ff) begin
               kind_in = slpi_pkg::EV_DUP;
               slot_in = '0;
               fin_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (pkt_end) start_fill_in = main_fill_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         main_fill_ff <= '0;
         over_fill_ff <= '0;
         sec_fill_ff <= '0;
         start_fill_ff <= '0;
         fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         main_fill_ff <= main_fill_in;
         over_fill_ff <= over_fill_in;
         sec_fill_ff <= sec_fill_in;
         start_fill_ff <= start_fill_in;
         fin_ff <= fin_in;
      end
      idx_ff <= idx_in;
      rec_ff <= rec_in;
      mode_ff <= mode_in;
      kind_ff <= kind_in;
      slot_ff <= slot_in;
   end

   assign busy = (state_ff != S_IDLE) || fin_ff;
   assign fin = fin_ff;
   assign kind = kind_ff;
   assign slot = slot_ff;
   // count of the list that the current mode targets
   assign main_count = req.mode ? 12'(main_fill_ff) : 12'(sec_fill_ff);
   assign over_count = 12'(over_fill_ff);

   `ASSERT_ALWAYS(a_start_le_main, clock, reset, start_fill_ff <= main_fill_ff)
   `ASSERT_IMPLIES(a_cmp_follows_read, clock, reset, state_ff == S_CMP,
      $past(state_ff) == S_READ)
   `ASSERT_IMPLIES(a_no_start_busy, clock, reset, state_ff != S_IDLE, !req.start)
endmodule

@@ rtl/server_list_packet_parse_insert.sv @@
// server list reply parser: byte stream in, one beat per record or packet end out
// uses slpi_pkg, slpi_lists and assert_macros.svh
// a packet end that stores no record gives its beat in the next cycle; a closing
// backslash gives its beat after the store (global mode: after a main-list scan
// to the packet start fill, ending at a duplicate); input stalls until beat is taken
// synchronous active-high reset clears the parser, fill counts and mode (to 1)
`include "assert_macros.svh"
module server_list_packet_parse_insert (
   input logic clock,
   input logic reset,
   input logic csr_we,
   input logic csr_wdata,
   input logic req_tvalid,
   output logic req_tready,
   input logic [7:0] req_tdata, // data_byte
   input logic req_tlast, // last_byte
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [87:0] rsp_tdata, // event_kind, slot_index, record_ip, record_port,
                                  // main_count, overflow_count, zero pad
   output logic rsp_tlast // packet_done
);
   localparam logic [1:0] PH_SEEK = 2'd0;
   localparam logic [1:0] PH_COLLECT = 2'd1;
   localparam logic [1:0] PH_CHECK = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   logic mode_ff;
   logic [1:0] phase_ff, phase_in;
   logic [47:0] rec_ff, rec_in;
   logic [2:0] pos_ff, pos_in;
   logic arm_ff, arm_in;
   logic [slpi_pkg::PktW-1:0] npkt_ff, npkt_in;
   logic wait_ff, wait_in;
   logic wlast_ff, wlast_in;
   logic [47:0] wrec_ff, wrec_in;
   logic ov_ff;
   slpi_pkg::rsp_type out_ff;
   slpi_pkg::ins_req_type ireq;
   logic lbusy, lfin, pend;
   logic [2:0] lkind;
   logic [10:0] lslot;
   logic [11:0] lmain, lover;
   logic acc;
   logic [7:0] expect_ch;

   assign acc = req_tvalid && req_tready;
   assign req_tready = !wait_ff && !lbusy && !ov_ff;

   always_comb begin
      unique case (pos_ff[1:0])
         2'd0: expect_ch = slpi_pkg::CH_E;
         2'd1: expect_ch = slpi_pkg::CH_O;
         default: expect_ch = slpi_pkg::CH_T;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      rec_in = rec_ff;
      pos_in = pos_ff;
      arm_in = arm_ff;
      npkt_in = npkt_ff;
      wait_in = wait_ff;
      wlast_in = wlast_ff;
      wrec_in = wrec_ff;
      ireq = '0;
      ireq.mode = mode_ff;
      pend = 1'b0;
      if (acc) begin
         unique case (phase_ff)
            PH_SEEK: begin
               if (req_tdata == slpi_pkg::BSLASH) begin
                  phase_in = PH_COLLECT;
                  pos_in = '0;
                  rec_in = '0;
                  arm_in = 1'b0;
               end
            end
            PH_COLLECT: begin
               rec_in = {rec_ff[39:0], req_tdata};
               pos_in = pos_ff + 1'b1;
               if (pos_ff == 3'd5) phase_in = PH_CHECK;
               arm_in = 1'b0;
               if (arm_ff && pos_ff < 3'd3 && req_tdata == expect_ch) begin
                  if (pos_ff == 3'd2) begin
                     phase_in = PH_DONE;
                     pos_in = pos_ff;
                  end else begin
                     arm_in = 1'b1;
                  end
               end
            end
            PH_CHECK: begin
               if (req_tdata == slpi_pkg::BSLASH) begin
                  ireq.start = 1'b1;
                  ireq.rec = rec_ff;
                  wait_in = 1'b1;
                  wrec_in = rec_ff;
                  wlast_in = req_tlast;
                  npkt_in = npkt_ff + 1'b1;
                  if (npkt_in >= slpi_pkg::PktW'(slpi_pkg::RecPerPkt)) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_COLLECT;
                     pos_in = '0;
                     rec_in = '0;
                     arm_in = 1'b1;
                  end
               end else begin
                  phase_in = PH_DONE;
               end
            end
            default: ;
         endcase
         if (req_tlast) begin
            phase_in = PH_SEEK;
            rec_in = '0;
            pos_in = '0;
            arm_in = 1'b0;
            npkt_in = '0;
         end
      end
      if (lfin) wait_in = 1'b0;
      // start fill follows main fill at the packet end, after any insert
      if (lfin && wlast_ff) pend = 1'b1;
      if (acc && req_tlast && !ireq.start) pend = 1'b1;
   end

   slpi_lists u_lists (
      .clock(clock),
      .reset(reset),
      .req(ireq),
      .pkt_end(pend),
      .busy(lbusy),
      .fin(lfin),
      .kind(lkind),
      .slot(lslot),
      .main_count(lmain),
      .over_count(lover)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         phase_ff <= PH_SEEK;
         pos_ff <= '0;
         arm_ff <= 1'b0;
         npkt_ff <= '0;
         wait_ff <= 1'b0;
         ov_ff <= 1'b0;
         rec_ff <= '0;
      end else begin
         if (csr_we) mode_ff <= csr_wdata;
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         arm_ff <= arm_in;
         npkt_ff <= npkt_in;
         wait_ff <= wait_in;
         rec_ff <= rec_in;
         if (lfin || (acc && req_tlast && !ireq.start)) ov_ff <= 1'b1;
         else if (rsp_tready) ov_ff <= 1'b0;
      end
      wlast_ff <= wlast_in;
      wrec_ff <= wrec_in;
      if (lfin) begin
         out_ff.kind <= lkind;
         out_ff.slot <= lslot;
         out_ff.rec <= wrec_ff;
         out_ff.main_count <= lmain;
         out_ff.over_count <= lover;
         out_ff.done <= wlast_ff;
      end else if (acc && req_tlast && !ireq.start) begin
         out_ff.kind <= slpi_pkg::EV_END;
         out_ff.slot <= '0;
         out_ff.rec <= '0;
         out_ff.main_count <= lmain;
         out_ff.over_count <= lover;
         out_ff.done <= 1'b1;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {2'd0, out_ff.over_count, out_ff.main_count, out_ff.rec[15:0],
                       out_ff.rec[47:16], out_ff.slot, out_ff.kind};
   assign rsp_tlast = out_ff.done;

   `ASSERT_IMPLIES(a_no_accept_while_wait, clock, reset, wait_ff, !req_tready)
   `ASSERT_IMPLIES(a_fin_only_waiting, clock, reset, lfin, wait_ff)
   `ASSERT_IMPLIES(a_pos_range, clock, reset, phase_ff == PH_COLLECT, pos_ff < 3'd6)
endmodule
